// ----- design/pcas_pkg.sv -----
// ----------------------------------------------------------------------------
// pcas_pkg - shared types and constants for the per-channel affine scaler
// Layout and register codes, configuration and pipeline control structs.
// ----------------------------------------------------------------------------
package pcas_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_BITS      = $clog2(MAX_CHANNELS);
  localparam int GAIN_BITS    = 16;
  localparam int FRAC_BITS    = 12;
  localparam int LANES        = 8;
  localparam int LANE_BITS    = $clog2(LANES);
  localparam int EPC_BITS     = 16;
  localparam int NCH_BITS     = 7;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [1:0] LAYOUT_PLANAR      = 2'd0;
  localparam logic [1:0] LAYOUT_INTERLEAVED = 2'd1;
  localparam logic [1:0] LAYOUT_BLOCKED     = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LAYOUT_MODE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENTS      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_USE_ALPHA     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_USE_BETA      = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef struct packed {
    logic [1:0]          layout_mode;
    logic [NCH_BITS-1:0] channel_count;
    logic [EPC_BITS-1:0] spatial_len;
    logic                use_alpha;
    logic                use_beta;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- design/pcas_cfg.sv -----
// ----------------------------------------------------------------------------
// pcas_cfg - configuration register file
// Five registers written through the configuration channel; unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module pcas_cfg
  import pcas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_mode   <= LAYOUT_PLANAR;
      cfg.channel_count <= NCH_BITS'(1);
      cfg.spatial_len   <= EPC_BITS'(1);
      cfg.use_alpha     <= 1'b1;
      cfg.use_beta      <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LAYOUT_MODE:   cfg.layout_mode   <= wr_data[1:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= wr_data[NCH_BITS-1:0];
        REG_ELEMENTS:      cfg.spatial_len   <= wr_data[EPC_BITS-1:0];
        REG_USE_ALPHA:     cfg.use_alpha     <= wr_data[0];
        REG_USE_BETA:      cfg.use_beta      <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/pcas_chan_seq.sv -----
// ----------------------------------------------------------------------------
// pcas_chan_seq - layout counters
// Works out the channel of the current sample and steps the channel,
// element and lane counters for planar, interleaved and blocked layouts.
// ----------------------------------------------------------------------------
module pcas_chan_seq
  import pcas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               step,
  input  logic               last,
  output logic [CH_BITS-1:0] ch
);

  logic [CH_BITS-1:0]   chan_cnt, chan_cnt_next;
  logic [EPC_BITS-1:0]  elem_cnt, elem_cnt_next;
  logic [LANE_BITS-1:0] lane_cnt, lane_cnt_next;

  logic [NCH_BITS-1:0]  nch;
  logic [NCH_BITS-1:0]  nch_round;
  logic [3:0]           nblk;
  logic [EPC_BITS-1:0]  epc;
  logic [EPC_BITS-1:0]  elem_cur;
  logic [EPC_BITS:0]    elem_inc;
  logic [CH_BITS-1:0]   chan_cur;
  logic [NCH_BITS-1:0]  chan_limit;
  logic [NCH_BITS-1:0]  chan_inc;
  logic                 elem_wrap;

  always_comb begin
    if (cfg.channel_count == '0)
      nch = NCH_BITS'(1);
    else if (cfg.channel_count > NCH_BITS'(MAX_CHANNELS))
      nch = NCH_BITS'(MAX_CHANNELS);
    else
      nch = cfg.channel_count;
    nch_round = nch + NCH_BITS'(LANES - 1);
    nblk      = nch_round[NCH_BITS-1:LANE_BITS];
    epc       = (cfg.spatial_len == '0) ? EPC_BITS'(1) : cfg.spatial_len;
    elem_cur  = (elem_cnt >= epc) ? '0 : elem_cnt;
    elem_inc  = {1'b0, elem_cur} + (EPC_BITS+1)'(1);
    elem_wrap = (elem_inc >= {1'b0, epc});
    chan_limit = (cfg.layout_mode == LAYOUT_BLOCKED) ? {3'b000, nblk} : nch;
    chan_cur  = ({1'b0, chan_cnt} >= chan_limit) ? '0 : chan_cnt;
    chan_inc  = {1'b0, chan_cur} + NCH_BITS'(1);
  end

  always_comb begin
    chan_cnt_next = chan_cnt;
    elem_cnt_next = elem_cur;
    lane_cnt_next = lane_cnt;
    unique case (cfg.layout_mode)
      LAYOUT_BLOCKED: begin
        ch            = {chan_cur[CH_BITS-LANE_BITS-1:0], lane_cnt};
        lane_cnt_next = lane_cnt + LANE_BITS'(1);
        chan_cnt_next = chan_cur;
        if (lane_cnt == LANE_BITS'(LANES - 1)) begin
          if (elem_wrap) begin
            elem_cnt_next = '0;
            chan_cnt_next = (chan_inc >= chan_limit) ? '0 : chan_inc[CH_BITS-1:0];
          end else begin
            elem_cnt_next = elem_inc[EPC_BITS-1:0];
          end
        end
      end
      LAYOUT_INTERLEAVED: begin
        ch            = chan_cur;
        chan_cnt_next = (chan_inc >= chan_limit) ? '0 : chan_inc[CH_BITS-1:0];
      end
      default: begin
        ch            = chan_cur;
        chan_cnt_next = chan_cur;
        if (elem_wrap) begin
          elem_cnt_next = '0;
          chan_cnt_next = (chan_inc >= chan_limit) ? '0 : chan_inc[CH_BITS-1:0];
        end else begin
          elem_cnt_next = elem_inc[EPC_BITS-1:0];
        end
      end
    endcase
    if (last) begin
      chan_cnt_next = '0;
      elem_cnt_next = '0;
      lane_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= '0;
      elem_cnt <= '0;
      lane_cnt <= '0;
    end else if (step) begin
      chan_cnt <= chan_cnt_next;
      elem_cnt <= elem_cnt_next;
      lane_cnt <= lane_cnt_next;
    end
  end

endmodule

// ----- design/pcas_coef_mem.sv -----
// ----------------------------------------------------------------------------
// pcas_coef_mem - gain and offset tables
// One write port for coefficient beats, one registered read port that
// holds its data while the pipeline stalls.
// ----------------------------------------------------------------------------
module pcas_coef_mem
  import pcas_pkg::*;
#(
  parameter int SAMPLE_BITS = pcas_pkg::SAMPLE_BITS
)
(
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [CH_BITS-1:0]     wr_addr,
  input  logic [GAIN_BITS-1:0]   wr_gain,
  input  logic [SAMPLE_BITS-1:0] wr_offset,
  input  logic                   rd_en,
  input  logic [CH_BITS-1:0]     rd_addr,
  output logic [GAIN_BITS-1:0]   rd_gain,
  output logic [SAMPLE_BITS-1:0] rd_offset
);

  logic [GAIN_BITS-1:0]   gain_mem   [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] offset_mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gain_mem[wr_addr]   <= wr_gain;
      offset_mem[wr_addr] <= wr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_gain   <= gain_mem[rd_addr];
      rd_offset <= offset_mem[rd_addr];
    end
  end

endmodule

// ----- design/pcas_datapath.sv -----
// ----------------------------------------------------------------------------
// pcas_datapath - multiply, round and saturate
// Stage 1 holds the sample, stage 2 the gain product, stage 3 the rounded
// and clipped result.
// ----------------------------------------------------------------------------
module pcas_datapath
  import pcas_pkg::*;
#(
  parameter int SAMPLE_BITS = pcas_pkg::SAMPLE_BITS
)
(
  input  logic                   clk,
  input  stage_en_t              en,
  input  cfg_t                   cfg,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [CH_BITS-1:0]     ch_in,
  input  logic [GAIN_BITS-1:0]   gain,
  input  logic [SAMPLE_BITS-1:0] offset,
  output logic [SAMPLE_BITS-1:0] result_value,
  output logic                   saturated,
  output logic [CH_BITS-1:0]     channel_used
);

  localparam int PROD_W = GAIN_BITS + SAMPLE_BITS;
  localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS + 6;
  localparam int Q_W    = ACC_W - FRAC_BITS;
  localparam int TOP_W  = Q_W - SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] x1;
  logic        [CH_BITS-1:0]     ch1;

  logic signed [GAIN_BITS-1:0]   gain_sel;
  logic signed [PROD_W-1:0]      prod_next;
  logic signed [PROD_W-1:0]      prod2;
  logic        [SAMPLE_BITS-1:0] beta2;
  logic        [CH_BITS-1:0]     ch2;

  logic        [ACC_W-1:0]       acc;
  logic        [Q_W-1:0]         q;
  logic        [TOP_W-1:0]       q_top;
  logic                          ovf;
  logic        [SAMPLE_BITS-1:0] result_next;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      x1  <= sample_in;
      ch1 <= ch_in;
    end
  end

  always_comb begin
    gain_sel  = cfg.use_alpha ? gain : GAIN_BITS'(1 << FRAC_BITS);
    prod_next = gain_sel * x1;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod2 <= prod_next;
      beta2 <= cfg.use_beta ? offset : '0;
      ch2   <= ch1;
    end
  end

  // floor((a*x + b*4096 + 2048) / 4096), rounds half upwards
  always_comb begin
    acc = {{(ACC_W-PROD_W){prod2[PROD_W-1]}}, prod2}
        + {{(ACC_W-SAMPLE_BITS-FRAC_BITS){beta2[SAMPLE_BITS-1]}}, beta2, {FRAC_BITS{1'b0}}}
        + {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    q     = acc[ACC_W-1:FRAC_BITS];
    q_top = q[Q_W-1:SAMPLE_BITS-1];
    ovf   = !((q_top == '0) || (q_top == '1));
    if (!ovf)
      result_next = q[SAMPLE_BITS-1:0];
    else if (q[Q_W-1])
      result_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else
      result_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      result_value <= result_next;
      saturated    <= ovf;
      channel_used <= ch2;
    end
  end

endmodule

// ----- design/per_channel_affine_scale.sv -----
// ----------------------------------------------------------------------------
// per_channel_affine_scale - per-channel scale and bias, y = alpha[ch]*x + beta[ch]
//
// Slave stream carries sample beats (tuser 0) and coefficient beats (tuser 1);
// coefficient beats load one channel's Q3.12 gain and offset and give no
// output. tlast on a sample beat returns the layout counters to zero.
// The master stream gives one beat per sample: rounded, clipped result,
// channel used, and a clip flag in tuser.
// Configuration writes go through cfg_valid/cfg_index/cfg_data, always ready,
// and must be issued only while the block is idle; the block does not enforce this.
// Stages: table read, multiply, round and clip. Throughput: one beat per cycle
// while the output is not stalled, set by the single multiplier stage and
// the one read port of the coefficient tables.
// Reset: configuration returns to planar, one channel, one element, gain and
// offset enabled; counters clear; tables hold nothing until written.
// When m_tready is low the pipeline holds and s_tready falls only once all
// three stages are full.
// ----------------------------------------------------------------------------
module per_channel_affine_scale
  import pcas_pkg::*;
#(
  parameter int SAMPLE_BITS = pcas_pkg::SAMPLE_BITS,
  localparam int IN_FIELDS_W  = SAMPLE_BITS + CH_BITS + GAIN_BITS + SAMPLE_BITS,
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = SAMPLE_BITS + CH_BITS,
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // sample, coef_index, alpha_word, beta_word, zero fill
  input  logic [IN_TDATA_W-1:0]    s_tdata,
  // cmd
  input  logic                     s_tuser,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // result_value, channel_used, zero fill
  output logic [OUT_TDATA_W-1:0]   m_tdata,
  // saturated
  output logic                     m_tuser,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int IDX_LO   = SAMPLE_BITS;
  localparam int ALPHA_LO = IDX_LO + CH_BITS;
  localparam int BETA_LO  = ALPHA_LO + GAIN_BITS;

  cfg_t      cfg;
  stage_en_t en;
  logic      v1, v2, v3;
  logic      in_beat;
  logic      sample_beat;
  logic      coef_beat;

  logic [SAMPLE_BITS-1:0] in_sample;
  logic [CH_BITS-1:0]     in_index;
  logic [GAIN_BITS-1:0]   in_alpha;
  logic [SAMPLE_BITS-1:0] in_beta;

  logic [CH_BITS-1:0]     ch;
  logic [GAIN_BITS-1:0]   rd_gain;
  logic [SAMPLE_BITS-1:0] rd_offset;
  logic [SAMPLE_BITS-1:0] result_value;
  logic [CH_BITS-1:0]     channel_used;

  assign in_sample = s_tdata[SAMPLE_BITS-1:0];
  assign in_index  = s_tdata[ALPHA_LO-1:IDX_LO];
  assign in_alpha  = s_tdata[BETA_LO-1:ALPHA_LO];
  assign in_beta   = s_tdata[BETA_LO+SAMPLE_BITS-1:BETA_LO];

  always_comb begin
    en.s3       = !v3 || m_tready;
    en.s2       = !v2 || en.s3;
    en.s1       = !v1 || en.s2;
    s_tready    = en.s1;
    in_beat     = s_tvalid && s_tready;
    sample_beat = in_beat && (s_tuser == CMD_SAMPLE);
    coef_beat   = in_beat && (s_tuser == CMD_COEF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= sample_beat;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

  assign cfg_ready = 1'b1;

  pcas_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pcas_chan_seq u_chan_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (sample_beat),
    .last (s_tlast),
    .ch   (ch)
  );

  pcas_coef_mem #(.SAMPLE_BITS(SAMPLE_BITS)) u_coef_mem (
    .clk       (clk),
    .wr_en     (coef_beat),
    .wr_addr   (in_index),
    .wr_gain   (in_alpha),
    .wr_offset (in_beta),
    .rd_en     (en.s1),
    .rd_addr   (ch),
    .rd_gain   (rd_gain),
    .rd_offset (rd_offset)
  );

  pcas_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
    .clk          (clk),
    .en           (en),
    .cfg          (cfg),
    .sample_in    (in_sample),
    .ch_in        (ch),
    .gain         (rd_gain),
    .offset       (rd_offset),
    .result_value (result_value),
    .saturated    (m_tuser),
    .channel_used (channel_used)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, channel_used, result_value};

endmodule

// ----- design/pcas_checker.sv -----
// ----------------------------------------------------------------------------
// pcas_checker - port-level checks for the per-channel affine scaler
// Watches the top-level ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module pcas_checker
  import pcas_pkg::*;
#(
  parameter int SAMPLE_BITS = pcas_pkg::SAMPLE_BITS
)
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [SAMPLE_BITS-1:0] m_tdata_res,
  input logic                   m_tuser
);

  localparam logic [SAMPLE_BITS-1:0] RES_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] RES_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata_res) && $stable(m_tuser))
    else $error("stalled output beat changed");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata_res == RES_MAX) || (m_tdata_res == RES_MIN))
    else $error("clip flag set on an unclipped result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output side free");

endmodule

bind per_channel_affine_scale pcas_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcas_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tready    (s_tready),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata_res (m_tdata[SAMPLE_BITS-1:0]),
  .m_tuser     (m_tuser)
);
